>>> src/l4s_path_detector_assert.svh
// Assertion macros shared by the path detector RTL.
`ifndef L4S_PATH_DETECTOR_ASSERT_SVH
`define L4S_PATH_DETECTOR_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define L4S_ASSERT_IMPL(label, clk, rstn, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rstn) (lhs) |-> (rhs)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define L4S_ASSERT_NEXT(label, clk, rstn, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rstn) (lhs) |=> (rhs)) \
        else $error("assertion failed");
`endif

>>> src/l4s_pkg.sv
// Package with shared types and codes of the path detector.
`default_nettype none
package l4s_pkg;
    localparam logic [1:0] OP_SEND   = 2'd0;
    localparam logic [1:0] OP_ACK    = 2'd1;
    localparam logic [1:0] OP_LOSS   = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam logic [1:0] CP_NONE = 2'd0;
    localparam logic [1:0] CP_ECT1 = 2'd1;
    localparam logic [1:0] CP_ECT0 = 2'd2;

    localparam logic [1:0] ST_UNKNOWN  = 2'd0;
    localparam logic [1:0] ST_PROBING  = 2'd1;
    localparam logic [1:0] ST_ENABLED  = 2'd2;
    localparam logic [1:0] ST_DISABLED = 2'd3;

    localparam logic [2:0] REG_ENABLE  = 3'd0;
    localparam logic [2:0] REG_CE_TH   = 3'd1;
    localparam logic [2:0] REG_CL_TH   = 3'd2;
    localparam logic [2:0] REG_PROBE_P = 3'd3;
    localparam logic [2:0] REG_PROBE_R = 3'd4;

    typedef struct packed {
        logic [1:0]  op;
        logic [61:0] ect1_total;
        logic [61:0] ce_total;
        logic [31:0] lost_packets;
    } l4s_item_t;

    typedef struct packed {
        logic [1:0]  codepoint;
        logic [1:0]  path_state;
        logic        path_capable;
        logic [10:0] alpha;
        logic        feedback_ignored;
    } l4s_result_t;
endpackage
`default_nettype wire

>>> src/l4s_fifo.sv
// Short queue between the input front end and the processing engine.
`default_nettype none
module l4s_fifo
    import l4s_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      wr_valid,
    output logic           wr_ready,
    input  wire l4s_item_t wr_data,
    output logic           rd_valid,
    input  wire logic      rd_ready,
    output l4s_item_t      rd_data
);
    l4s_item_t  mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       do_wr, do_rd;

    assign wr_ready = (cnt_reg != 2'd2);
    assign rd_valid = (cnt_reg != 2'd0);
    assign rd_data  = mem_reg[rp_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;

    always_ff @(posedge aclk) begin
        if (do_wr) begin
            mem_reg[wp_reg] <= wr_data;
        end
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (do_wr) wp_reg <= ~wp_reg;
            if (do_rd) rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, do_wr} - {1'b0, do_rd};
        end
    end
endmodule
`default_nettype wire

>>> src/l4s_engine.sv
// Processing engine: state updates, serial fraction divider and detection rules.
`default_nettype none
module l4s_engine
    import l4s_pkg::*;
#(
    parameter int ALPHA_SHIFT = 4
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire l4s_item_t   in_item,
    output logic             out_valid,
    input  wire logic        out_ready,
    output l4s_result_t      out_res,
    input  wire logic        cfg_valid,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);
    typedef enum logic [2:0] {S_IDLE, S_DIV, S_ALPHA, S_DETECT, S_OUT} state_t;
    localparam int ONE = 1024;
    localparam logic [10:0] ONE_BITS = 11'(ONE);

    state_t      state_reg;
    logic        en_reg;
    logic [15:0] ce_th_reg, cl_th_reg, pp_reg;
    logic [7:0]  pr_reg;
    logic [1:0]  ps_reg;
    logic        cap_reg;
    logic [10:0] alpha_reg;
    logic [31:0] ce_seen_reg, loss_seen_reg;
    logic [7:0]  round_reg;
    logic [15:0] res_reg;
    logic        sent_any_reg;
    logic [61:0] last_ce_reg, last_e1_reg;
    logic [62:0] den_reg, rem_reg;
    logic [61:0] dce_reg;
    logic [10:0] q_reg;
    logic [3:0]  bit_reg;
    logic [1:0]  cp_reg;
    logic        ign_reg;
    l4s_result_t res_out_reg;
    logic        out_valid_reg;

    logic [61:0] dce, de1;
    logic [63:0] r2, r3;
    logic        sub1, sub2;
    logic        b;
    logic [32:0] ce_sum, loss_sum;
    logic [16:0] resp1;

    assign in_ready  = (state_reg == S_IDLE) && !out_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_res   = res_out_reg;

    assign dce = in_item.ce_total - last_ce_reg;
    assign de1 = in_item.ect1_total - last_e1_reg;
    assign b   = ONE_BITS[bit_reg];
    always_comb begin
        r2 = {rem_reg, 1'b0};
        sub1 = (r2 >= {1'b0, den_reg});
        if (sub1) r2 = r2 - {1'b0, den_reg};
        r3 = r2 + (b ? {2'b0, dce_reg} : 64'd0);
        sub2 = (r3 >= {1'b0, den_reg});
        if (sub2) r3 = r3 - {1'b0, den_reg};
    end
    assign resp1 = {1'b0, res_reg} + 17'd1;
    assign ce_sum = {1'b0, ce_seen_reg} +
                    ((dce > 62'hFFFFFFFF) ? 33'hFFFFFFFF : {1'b0, dce[31:0]});
    assign loss_sum = {1'b0, loss_seen_reg} + {1'b0, in_item.lost_packets};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE; en_reg <= 1'b0; ce_th_reg <= 16'd10;
            cl_th_reg <= 16'd5; pp_reg <= 16'd100; pr_reg <= 8'd3;
            ps_reg <= ST_UNKNOWN; cap_reg <= 1'b0; alpha_reg <= '0;
            ce_seen_reg <= '0; loss_seen_reg <= '0; round_reg <= '0;
            res_reg <= '0; sent_any_reg <= 1'b0; last_ce_reg <= '0;
            last_e1_reg <= '0; out_valid_reg <= 1'b0;
        end else begin
            if (out_valid_reg && out_ready) out_valid_reg <= 1'b0;
            if (cfg_valid) begin
                case (cfg_index)
                    REG_ENABLE: begin
                        en_reg <= cfg_data[0];
                        if (cfg_data[0] && ps_reg == ST_UNKNOWN) begin
                            ps_reg <= ST_PROBING; round_reg <= '0;
                            ce_seen_reg <= '0; loss_seen_reg <= '0;
                        end else if (!cfg_data[0]) begin
                            ps_reg <= ST_DISABLED; cap_reg <= 1'b0;
                        end
                    end
                    REG_CE_TH:   ce_th_reg <= cfg_data;
                    REG_CL_TH:   cl_th_reg <= cfg_data;
                    REG_PROBE_P: pp_reg <= cfg_data;
                    REG_PROBE_R: pr_reg <= cfg_data[7:0];
                    default: ;
                endcase
            end
            case (state_reg)
                S_IDLE: if (in_valid && in_ready) begin
                    cp_reg <= CP_NONE; ign_reg <= 1'b0; state_reg <= S_OUT;
                    case (in_item.op)
                        OP_SEND: begin
                            if (en_reg && (ps_reg == ST_ENABLED || ps_reg == ST_PROBING)) begin
                                cp_reg <= CP_ECT1; sent_any_reg <= 1'b1;
                                res_reg <= (resp1 >= {1'b0, pp_reg}) ? 16'd0 : resp1[15:0];
                            end else cp_reg <= CP_ECT0;
                        end
                        OP_ACK: begin
                            if (in_item.ce_total < last_ce_reg ||
                                in_item.ect1_total < last_e1_reg) begin
                                ign_reg <= 1'b1;
                            end else begin
                                last_ce_reg <= in_item.ce_total;
                                last_e1_reg <= in_item.ect1_total;
                                state_reg <= S_DETECT;
                                if (dce != '0) begin
                                    ce_seen_reg <= ce_sum[32] ? 32'hFFFFFFFF : ce_sum[31:0];
                                    dce_reg <= dce; den_reg <= {1'b0, dce} + {1'b0, de1};
                                    rem_reg <= '0; q_reg <= '0; bit_reg <= 4'd10;
                                    state_reg <= (de1 == '0) ? S_ALPHA : S_DIV;
                                    if (de1 == '0) q_reg <= 11'(ONE);
                                end
                            end
                        end
                        OP_LOSS: if (in_item.lost_packets != '0) begin
                            loss_seen_reg <= loss_sum[32] ? 32'hFFFFFFFF : loss_sum[31:0];
                            state_reg <= S_DETECT;
                        end
                        default: ;
                    endcase
                end
                S_DIV: begin
                    rem_reg <= r3[62:0];
                    q_reg <= {q_reg[9:0], 1'b0} + {10'd0, sub1} + {10'd0, sub2};
                    if (bit_reg == 4'd0) state_reg <= S_ALPHA;
                    else bit_reg <= bit_reg - 4'd1;
                end
                S_ALPHA: begin
                    logic [11:0] a;
                    a = {1'b0, alpha_reg} - {1'b0, 11'(alpha_reg >> ALPHA_SHIFT)}
                        + {1'b0, 11'(q_reg >> ALPHA_SHIFT)};
                    alpha_reg <= (a > 12'(ONE)) ? 11'(ONE) : a[10:0];
                    state_reg <= S_DETECT;
                end
                S_DETECT: begin
                    state_reg <= S_OUT;
                    if (en_reg && ps_reg == ST_PROBING) begin
                        if (ce_seen_reg >= {16'd0, ce_th_reg}) begin
                            ps_reg <= ST_ENABLED; cap_reg <= 1'b1;
                        end else if (loss_seen_reg >= {16'd0, cl_th_reg}) begin
                            ps_reg <= ST_DISABLED; cap_reg <= 1'b0;
                        end else if (sent_any_reg && res_reg == '0) begin
                            logic [7:0] nr;
                            nr = (round_reg != 8'hFF) ? round_reg + 8'd1 : round_reg;
                            round_reg <= nr;
                            if (nr >= pr_reg) begin
                                ps_reg <= (ce_seen_reg != '0) ? ST_ENABLED : ST_DISABLED;
                                cap_reg <= (ce_seen_reg != '0);
                            end
                        end
                    end else if (en_reg && ps_reg == ST_ENABLED) begin
                        if (loss_seen_reg >= {15'd0, cl_th_reg, 1'b0}) begin
                            ps_reg <= ST_PROBING; round_reg <= '0;
                            ce_seen_reg <= '0; loss_seen_reg <= '0;
                        end else if (ce_seen_reg > {15'd0, ce_th_reg, 1'b0}) begin
                            ce_seen_reg <= '0; loss_seen_reg <= '0;
                        end
                    end
                end
                S_OUT: begin
                    res_out_reg <= '{cp_reg, ps_reg, cap_reg, alpha_reg, ign_reg};
                    out_valid_reg <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

>>> src/l4s_path_detector.sv
// Top level of the L4S path detector.
// Usage:
// Items enter on the s_axis channel (tuser = op, tdata = ect1_total,
// ce_total, lost_packets) and each yields one result on m_axis.
// Every item passes a two-entry queue into a sequential engine.
// The engine takes each item from the queue straight to S_OUT for a send, an
// unused op, a backward ack or an empty loss; through S_DETECT to S_OUT for a
// loss or an ack without new CE marks; through S_ALPHA and S_DETECT for an ack
// with CE marks and no new ECT(1) count; and for an ack with both, first
// through the 11-step radix-2 fraction divider (S_DIV); S_OUT registers the
// result. The next queued item enters the cycle after the result transaction.
// Configuration writes on cfg_valid/cfg_index/cfg_data are always accepted
// and must be made while the block is idle.
// Synchronous active-low reset restores the register defaults and clears
// all path state. When m_axis_tready is low the result holds and the
// engine stalls; the queue keeps taking items until it is full.
`default_nettype none
module l4s_path_detector
    import l4s_pkg::*;
#(
    parameter int ALPHA_SHIFT = 4
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // tdata: ect1_total[61:0], ce_total[123:62], lost_packets[155:124]
    input  wire logic [159:0] s_axis_tdata,
    // tuser: op[1:0]
    input  wire logic [1:0]   s_axis_tuser,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // tdata: path_state[1:0], path_capable[2], alpha[13:3], feedback_ignored[14]
    output logic [15:0]       m_axis_tdata,
    // tuser: codepoint[1:0]
    output logic [1:0]        m_axis_tuser,
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [2:0]   cfg_index,
    input  wire logic [15:0]  cfg_data
);
    `include "l4s_path_detector_assert.svh"

    l4s_item_t   item, q_item;
    logic        q_valid, q_ready;
    l4s_result_t res;

    assign item = '{s_axis_tuser, s_axis_tdata[61:0], s_axis_tdata[123:62],
                    s_axis_tdata[155:124]};
    assign cfg_ready = 1'b1;

    l4s_fifo u_fifo (
        .aclk(aclk), .aresetn(aresetn),
        .wr_valid(s_axis_tvalid), .wr_ready(s_axis_tready), .wr_data(item),
        .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_item)
    );

    l4s_engine #(.ALPHA_SHIFT(ALPHA_SHIFT)) u_engine (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(q_valid), .in_ready(q_ready), .in_item(q_item),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_res(res),
        .cfg_valid(cfg_valid), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    assign m_axis_tdata = {1'b0, res.feedback_ignored, res.alpha,
                           res.path_capable, res.path_state};
    assign m_axis_tuser = res.codepoint;

    `L4S_ASSERT_NEXT(a_hold, aclk, aresetn, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata))
    `L4S_ASSERT_IMPL(a_alpha, aclk, aresetn, m_axis_tvalid, m_axis_tdata[13:3] <= 11'd1024)
    `L4S_ASSERT_IMPL(a_cp, aclk, aresetn, m_axis_tvalid && m_axis_tuser != CP_NONE,
        m_axis_tdata[14] == 1'b0)
endmodule
`default_nettype wire

>>> sim/l4s_path_detector_test.sv
// Self-checking testbench of the L4S path detector, with its own path state predictor.
`default_nettype none
module l4s_path_detector_test;
    import l4s_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [61:0] MAX62 = {62{1'b1}};
    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_PER_PHASE = 175;
    localparam int NUM_PHASES = 6;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [159:0] s_axis_tdata = '0;
    logic [1:0]   s_axis_tuser = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [15:0]  m_axis_tdata;
    logic [1:0]   m_axis_tuser;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [2:0]   cfg_index = '0;
    logic [15:0]  cfg_data = '0;

    l4s_path_detector u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Predicted path state and configuration.
    logic        p_enable;
    logic [15:0] p_ce_th, p_cl_th, p_probe_pkts;
    logic [7:0]  p_probe_rounds;
    logic [1:0]  p_state;
    logic        p_capable;
    logic [31:0] p_alpha, p_ce_marks, p_losses, p_round, p_residue;
    logic        p_sent_any;
    logic [61:0] p_last_ce, p_last_e1;

    l4s_result_t pending_results[$];
    int errors = 0;
    int cycles = 0;

    typedef struct {
        logic [1:0]  op;
        logic [61:0] e1;
        logic [61:0] ce;
        logic [31:0] lp;
        bit          typed;
        l4s_result_t res;
    } stim_row_t;

    function automatic logic [31:0] sat_add(logic [31:0] a, logic [63:0] b);
        logic [32:0] s;
        s = {1'b0, a} + ((b > 64'hFFFF_FFFF) ? 33'h0_FFFF_FFFF : {1'b0, b[31:0]});
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    function automatic logic [31:0] scaled_frac(logic [63:0] d, logic [63:0] t);
        logic [79:0] q;
        if (d >= t) return 32'd1024;
        q = ({16'd0, d} * 80'd1024) / {16'd0, t};
        return q[31:0];
    endfunction

    function automatic void restart_probing();
        p_state = ST_PROBING;
        p_round = 0;
        p_ce_marks = 0;
        p_losses = 0;
    endfunction

    function automatic void detect_rules();
        if (!p_enable) return;
        if (p_state == ST_PROBING) begin
            if (p_ce_marks >= p_ce_th) begin
                p_state = ST_ENABLED;
                p_capable = 1'b1;
            end else if (p_losses >= p_cl_th) begin
                p_state = ST_DISABLED;
                p_capable = 1'b0;
            end else if (p_sent_any && p_residue == 0) begin
                if (p_round < 255) p_round++;
                if (p_round >= p_probe_rounds) begin
                    p_state = (p_ce_marks > 0) ? ST_ENABLED : ST_DISABLED;
                    p_capable = (p_ce_marks > 0);
                end
            end
        end else if (p_state == ST_ENABLED) begin
            if (p_losses >= 2 * p_cl_th) begin
                restart_probing();
            end else if (p_ce_marks > 2 * p_ce_th) begin
                p_ce_marks = 0;
                p_losses = 0;
            end
        end
    endfunction

    function automatic l4s_result_t path_step(stim_row_t it);
        l4s_result_t r;
        logic [63:0] dce, de1;
        logic [31:0] a;
        r = '0;
        if (it.op == OP_SEND) begin
            if (p_enable && (p_state == ST_ENABLED || p_state == ST_PROBING)) begin
                r.codepoint = CP_ECT1;
                if (p_residue + 1 >= p_probe_pkts) p_residue = 0;
                else p_residue++;
                p_sent_any = 1'b1;
            end else begin
                r.codepoint = CP_ECT0;
            end
        end else if (it.op == OP_ACK) begin
            if (it.ce < p_last_ce || it.e1 < p_last_e1) begin
                r.feedback_ignored = 1'b1;
            end else begin
                dce = {2'b0, it.ce - p_last_ce};
                de1 = {2'b0, it.e1 - p_last_e1};
                p_last_ce = it.ce;
                p_last_e1 = it.e1;
                if (dce > 0) begin
                    p_ce_marks = sat_add(p_ce_marks, dce);
                    a = p_alpha - (p_alpha >> 4) + (scaled_frac(dce, dce + de1) >> 4);
                    p_alpha = (a > 1024) ? 32'd1024 : a;
                end
                detect_rules();
            end
        end else if (it.op == OP_LOSS) begin
            if (it.lp != 0) begin
                p_losses = sat_add(p_losses, {32'd0, it.lp});
                detect_rules();
            end
        end
        r.path_state = p_state;
        r.path_capable = p_capable;
        r.alpha = p_alpha[10:0];
        return r;
    endfunction

    task automatic report_mismatch(string field, int got, int want);
        $display("mismatch in %s: got %0d, expected %0d at cycle %0d", field, got, want, cycles);
        errors++;
    endtask

    task automatic write_reg(logic [2:0] idx, logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_ENABLE: begin
                p_enable = val[0];
                if (p_enable && p_state == ST_UNKNOWN) restart_probing();
                else if (!p_enable) begin
                    p_state = ST_DISABLED;
                    p_capable = 1'b0;
                end
            end
            REG_CE_TH:   p_ce_th = val;
            REG_CL_TH:   p_cl_th = val;
            REG_PROBE_P: p_probe_pkts = val;
            REG_PROBE_R: p_probe_rounds = val[7:0];
            default: ;
        endcase
        @(posedge aclk);
    endtask

    task automatic wait_idle();
        while (pending_results.size() > 0) @(posedge aclk);
        repeat (30) @(posedge aclk);
    endtask

    // Drives one item after a random gap and predicts it at acceptance.
    task automatic send_item(stim_row_t it);
        int gap;
        l4s_result_t r;
        gap = $urandom_range(0, 13);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= it.op;
        s_axis_tdata <= {4'd0, it.lp, it.ce, it.e1};
        do @(posedge aclk); while (!s_axis_tready);
        r = path_step(it);
        pending_results.push_back(it.typed ? it.res : r);
    endtask

    function automatic logic [61:0] bump(logic [61:0] base, logic [63:0] d);
        logic [63:0] s;
        s = {2'b0, base} + d;
        return (s > {2'b0, MAX62}) ? MAX62 : s[61:0];
    endfunction

    function automatic stim_row_t random_item();
        stim_row_t it;
        int pick;
        it = '{default: '0};
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
            it.op = OP_SEND;
            it.e1 = 62'({$urandom, $urandom});
            it.ce = 62'({$urandom, $urandom});
            it.lp = $urandom;
        end else if (pick < 75) begin
            it.op = OP_ACK;
            it.e1 = bump(p_last_e1, 64'($urandom_range(0, 20)));
            it.ce = bump(p_last_ce,
                         ($urandom_range(0, 3) == 0) ? 64'd0 : 64'($urandom_range(0, 12)));
            if ($urandom_range(0, 60) == 0) it.ce = bump(p_last_ce, {$urandom, $urandom} >> 3);
        end else if (pick < 79) begin
            it.op = OP_ACK;
            it.e1 = (p_last_e1 > 0 && $urandom_range(0, 1)) ? p_last_e1 - 1 : p_last_e1;
            it.ce = (it.e1 == p_last_e1 && p_last_ce > 0) ? p_last_ce - 1 : p_last_ce;
        end else if (pick < 80) begin
            it.op = OP_ACK;
            it.e1 = 62'({$urandom, $urandom});
            it.ce = 62'({$urandom, $urandom});
        end else if (pick < 95) begin
            it.op = OP_LOSS;
            it.lp = ($urandom_range(0, 40) == 0) ? $urandom : $urandom_range(0, 2);
            it.e1 = 62'({$urandom, $urandom});
        end else begin
            it.op = OP_UNUSED;
            it.e1 = 62'({$urandom, $urandom});
            it.ce = 62'({$urandom, $urandom});
            it.lp = $urandom;
        end
        return it;
    endfunction

    // Result side: random back-pressure and field-by-field comparison.
    initial begin
        int stall;
        l4s_result_t want;
        @(posedge aresetn);
        forever begin
            stall = $urandom_range(0, 13);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge aclk); while (!m_axis_tvalid);
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result transactions", 1, 0);
            end else begin
                want = pending_results.pop_front();
                if (m_axis_tuser != want.codepoint)
                    report_mismatch("codepoint", m_axis_tuser, want.codepoint);
                if (m_axis_tdata[1:0] != want.path_state)
                    report_mismatch("path_state", m_axis_tdata[1:0], want.path_state);
                if (m_axis_tdata[2] != want.path_capable)
                    report_mismatch("path_capable", m_axis_tdata[2], want.path_capable);
                if (m_axis_tdata[13:3] != want.alpha)
                    report_mismatch("alpha", m_axis_tdata[13:3], want.alpha);
                if (m_axis_tdata[14] != want.feedback_ignored)
                    report_mismatch("feedback_ignored", m_axis_tdata[14], want.feedback_ignored);
            end
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        stim_row_t directed[$];
        stim_row_t it;
        logic [15:0] phase_cfg[NUM_PHASES][5];
        p_enable = 0; p_ce_th = 10; p_cl_th = 5; p_probe_pkts = 100; p_probe_rounds = 3;
        p_state = ST_UNKNOWN; p_capable = 0; p_alpha = 0; p_ce_marks = 0; p_losses = 0;
        p_round = 0; p_residue = 0; p_sent_any = 0; p_last_ce = 0; p_last_e1 = 0;

        phase_cfg = '{'{1, 3, 1000, 4, 3}, '{1, 65535, 65535, 65535, 255},
                      '{1, 1, 300, 0, 1}, '{1, 20, 50, 2, 2},
                      '{0, 10, 1, 100, 3}, '{1, 2, 1, 1, 1}};

        directed.push_back('{OP_SEND, MAX62, MAX62, 32'hFFFF_FFFF, 1,
                             '{CP_ECT0, ST_UNKNOWN, 1'b0, 11'd0, 1'b0}});
        directed.push_back('{OP_UNUSED, MAX62, MAX62, 32'hFFFF_FFFF, 1,
                             '{CP_NONE, ST_UNKNOWN, 1'b0, 11'd0, 1'b0}});
        directed.push_back('{OP_ACK, 0, 0, 0, 0, '0});
        directed.push_back('{OP_ACK, 0, 5, 0, 0, '0});
        directed.push_back('{OP_ACK, 100, 5, 0, 0, '0});
        directed.push_back('{OP_ACK, 99, 6, 0, 0, '0});
        directed.push_back('{OP_ACK, 100, 4, 0, 0, '0});
        directed.push_back('{OP_ACK, 300, 105, 0, 0, '0});
        directed.push_back('{OP_LOSS, 0, 0, 0, 0, '0});
        directed.push_back('{OP_LOSS, 0, 0, 32'hFFFF_FFFF, 0, '0});
        directed.push_back('{OP_LOSS, 0, 0, 1, 0, '0});
        directed.push_back('{OP_ACK, MAX62, 106, 0, 0, '0});
        directed.push_back('{OP_ACK, MAX62, MAX62, 0, 0, '0});
        directed.push_back('{OP_SEND, 0, 0, 0, 0, '0});

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed[i]) send_item(directed[i]);
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        wait_idle();

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            wait_idle();
            write_reg(REG_CE_TH, phase_cfg[ph][1]);
            write_reg(REG_CL_TH, phase_cfg[ph][2]);
            write_reg(REG_PROBE_P, phase_cfg[ph][3]);
            write_reg(REG_PROBE_R, phase_cfg[ph][4]);
            write_reg(REG_ENABLE, phase_cfg[ph][0]);
            for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
                it = random_item();
                send_item(it);
            end
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end

        wait_idle();
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
`default_nettype wire
